// ===== src/ddtu_pkg.sv =====
// Package for the display dirty tile updater.
// Holds field widths, command byte constants, the controller state type and
// the result word type. No dependencies.
`default_nettype none

package ddtu_pkg;

   localparam int SCREEN_W = 2;
   localparam int PAGE_W   = 3;
   localparam int TILE_W   = 4;
   localparam int LANES    = 8;
   localparam int WORD_W   = 64;

   localparam int SCREENS_DEF = 4;
   localparam int PAGES_DEF   = 8;
   localparam int TILES_DEF   = 16;

   localparam logic [7:0] CMD_ZERO      = 8'h00;
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_MASK  = 8'h0F;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_CMD,
      ST_FETCH,
      ST_EMIT
   } ddtu_state_type;

   typedef logic [LANES-1:0][7:0] ddtu_bytes_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] out_screen;
      logic                kind;
      ddtu_bytes_type      out_bytes;
      logic                last_of_run;
   } ddtu_rsp_type;

endpackage

`default_nettype wire

// ===== src/ddtu_req_if.sv =====
// Tile input channel: valid/ready handshake with one 8x8 tile as payload.
// Depends on ddtu_pkg for the field widths.
`default_nettype none

interface ddtu_req_if
   import ddtu_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SCREEN_W-1:0] screen;
   logic [PAGE_W-1:0]   page;
   logic [TILE_W-1:0]   tile;
   logic [7:0]          row_byte_0;
   logic [7:0]          row_byte_1;
   logic [7:0]          row_byte_2;
   logic [7:0]          row_byte_3;
   logic [7:0]          row_byte_4;
   logic [7:0]          row_byte_5;
   logic [7:0]          row_byte_6;
   logic [7:0]          row_byte_7;

   modport source (
      output valid, screen, page, tile, row_byte_0, row_byte_1, row_byte_2,
             row_byte_3, row_byte_4, row_byte_5, row_byte_6, row_byte_7,
      input  ready
   );
   modport sink (
      input  valid, screen, page, tile, row_byte_0, row_byte_1, row_byte_2,
             row_byte_3, row_byte_4, row_byte_5, row_byte_6, row_byte_7,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/ddtu_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one command or data word.
// Depends on ddtu_pkg for the field widths.
`default_nettype none

interface ddtu_rsp_if
   import ddtu_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SCREEN_W-1:0] out_screen;
   logic                kind;
   logic [7:0]          out_byte_0;
   logic [7:0]          out_byte_1;
   logic [7:0]          out_byte_2;
   logic [7:0]          out_byte_3;
   logic [7:0]          out_byte_4;
   logic [7:0]          out_byte_5;
   logic [7:0]          out_byte_6;
   logic [7:0]          out_byte_7;
   logic                last_of_run;

   modport source (
      output valid, out_screen, kind, out_byte_0, out_byte_1, out_byte_2,
             out_byte_3, out_byte_4, out_byte_5, out_byte_6, out_byte_7,
             last_of_run,
      input  ready
   );
   modport sink (
      input  valid, out_screen, kind, out_byte_0, out_byte_1, out_byte_2,
             out_byte_3, out_byte_4, out_byte_5, out_byte_6, out_byte_7,
             last_of_run,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/ddtu_lane.sv =====
// One column lane: builds a vertical column byte from the eight row bytes
// and compares it with the stored byte. Depends on ddtu_pkg.
`default_nettype none

module ddtu_lane
   import ddtu_pkg::*;
#(
   parameter int LANE = 0
) (
   input  wire ddtu_bytes_type rows,
   input  wire logic [7:0]     old_byte,
   output logic [7:0]          col_byte,
   output logic                differs
);

   // Column LANE is bit 7-LANE of every row, since bit 7 is the leftmost pixel.
   localparam int SRC_BIT = 7 - LANE;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         col_byte[b] = rows[b][SRC_BIT];
      end
      differs = (col_byte != old_byte);
   end

endmodule

`default_nettype wire

// ===== src/ddtu_shadow.sv =====
// Shadow store of column words, one per screen, page and tile.
// Single write port, single read port with registered read data.
`default_nettype none

module ddtu_shadow
   import ddtu_pkg::*;
#(
   parameter int DEPTH = SCREENS_DEF * PAGES_DEF * TILES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0]      rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/display_dirty_tile_updater_core.sv =====
// Display dirty tile updater, top level.
//
// req_chan takes one 8x8 tile per word: screen, page, tile and eight row
// bytes. Tiles of a page must arrive in order; the block does not enforce
// this. Each tile is transposed into eight column bytes by eight lanes
// working side by side, the lane results are merged into one dirty flag,
// and the shadow word is rewritten. rsp_chan gives, at the last tile of a
// dirty page, one addressing command word and then one data word per tile
// of the dirty span.
//
// A tile is handled as a shadow read, then a compare and write: the single
// read-modify-write of the shadow memory. At a page end the command is
// loaded, then each data word is read from the shadow memory and loaded
// into the output register, so a burst of up to 17 words (at default size)
// holds off req_chan. The output register lets the next tile be taken while
// the last word still waits.
// Reset: after reset the block clears the shadow memory one word a cycle,
// all SCREENS*PAGES*TILES words (512 at default size), with req_chan not ready.
// A stalled rsp_chan holds its word and stops the burst; tiles are then
// taken only once the burst is fully loaded.
`default_nettype none

module display_dirty_tile_updater_core
   import ddtu_pkg::*;
#(
   parameter int SCREENS = SCREENS_DEF,
   parameter int PAGES   = PAGES_DEF,
   parameter int TILES   = TILES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ddtu_req_if.sink    req_chan,
   ddtu_rsp_if.source  rsp_chan
);

   localparam int DEPTH = SCREENS * PAGES * TILES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] shadow_addr(
      input logic [SCREEN_W-1:0] s,
      input logic [PAGE_W-1:0]   p,
      input logic [TILE_W-1:0]   t
   );
      return AW'((32'(s) * PAGES + 32'(p)) * TILES + 32'(t));
   endfunction

   ddtu_state_type state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [SCREEN_W-1:0] screen_ff, screen_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [TILE_W-1:0]   tile_ff, tile_in;
   ddtu_bytes_type      rows_ff, rows_in;
   logic [TILE_W-1:0]   first_ff, first_in;
   logic [TILE_W-1:0]   last_ff, last_in;
   logic                dirty_ff, dirty_in;
   logic [TILE_W-1:0]   k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ddtu_rsp_type        rsp_ff, rsp_in;

   logic                accept;
   logic                in_range;
   logic                slot_free;
   logic                tile_first, tile_end;
   logic                pd_eff;
   logic [AW-1:0]       req_addr, cur_addr, fetch_addr;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [WORD_W-1:0]   mem_wr_data, mem_rd_data;
   ddtu_bytes_type      new_cols, old_cols;
   logic [LANES-1:0]    lane_diff;
   logic                any_diff;
   logic [7:0]          col_addr;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign in_range  = (32'(req_chan.screen) < SCREENS) && (32'(req_chan.page) < PAGES) &&
                      (32'(req_chan.tile) < TILES);

   assign req_addr   = shadow_addr(req_chan.screen, req_chan.page, req_chan.tile);
   assign cur_addr   = shadow_addr(screen_ff, page_ff, tile_ff);
   assign fetch_addr = shadow_addr(screen_ff, page_ff, k_ff);

   // The read port runs every cycle; in LOOK and EMIT it holds the word
   // addressed in the cycle before.
   assign mem_rd_addr = (state_ff == ST_IDLE) ? req_addr : fetch_addr;
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_LOOK);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : cur_addr;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : WORD_W'(new_cols);

   ddtu_shadow #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign old_cols = ddtu_bytes_type'(mem_rd_data);

   for (genvar x = 0; x < LANES; x++) begin : g_lane
      ddtu_lane #(
         .LANE (x)
      ) u_lane (
         .rows     (rows_ff),
         .old_byte (old_cols[x]),
         .col_byte (new_cols[x]),
         .differs  (lane_diff[x])
      );
   end

   // Merge stage: the tile is dirty if any lane saw a change.
   assign any_diff = |lane_diff;

   assign tile_first = (tile_ff == '0);
   assign tile_end   = (32'(tile_ff) == TILES - 1);
   assign pd_eff     = tile_first ? 1'b0 : dirty_ff;
   assign col_addr   = {1'b0, first_ff, 3'b000};

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      screen_in    = screen_ff;
      page_in      = page_ff;
      tile_in      = tile_ff;
      rows_in      = rows_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      dirty_in     = dirty_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               screen_in = req_chan.screen;
               page_in   = req_chan.page;
               tile_in   = req_chan.tile;
               rows_in   = {req_chan.row_byte_7, req_chan.row_byte_6,
                            req_chan.row_byte_5, req_chan.row_byte_4,
                            req_chan.row_byte_3, req_chan.row_byte_2,
                            req_chan.row_byte_1, req_chan.row_byte_0};
               if (in_range) begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            dirty_in = pd_eff;
            if (any_diff) begin
               if (!pd_eff) begin
                  first_in = tile_ff;
               end
               last_in  = tile_ff;
               dirty_in = 1'b1;
            end
            if (tile_end && (any_diff || pd_eff)) begin
               state_in = ST_CMD;
            end else begin
               state_in = ST_IDLE;
               if (tile_end) begin
                  dirty_in = 1'b0;
               end
            end
         end
         ST_CMD: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.out_screen     = screen_ff;
               rsp_in.kind           = KIND_CMD;
               rsp_in.out_bytes      = '0;
               rsp_in.out_bytes[0]   = CMD_ZERO;
               rsp_in.out_bytes[1]   = CMD_PAGE_BASE | 8'(page_ff);
               rsp_in.out_bytes[2]   = col_addr & CMD_COL_MASK;
               rsp_in.out_bytes[3]   = CMD_COL_HIGH | (col_addr >> 4);
               rsp_in.last_of_run    = 1'b0;
               k_in                  = first_ff;
               // Tiles sent out of order can leave the span reversed; then
               // the command goes out alone.
               if (first_ff > last_ff) begin
                  dirty_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_screen  = screen_ff;
               rsp_in.kind        = KIND_DATA;
               rsp_in.out_bytes   = old_cols;
               rsp_in.last_of_run = (k_ff == last_ff);
               if (k_ff == last_ff) begin
                  dirty_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      screen_ff <= screen_in;
      page_ff   <= page_in;
      tile_ff   <= tile_in;
      rows_ff   <= rows_in;
      k_ff      <= k_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_screen  = rsp_ff.out_screen;
   assign rsp_chan.kind        = rsp_ff.kind;
   assign rsp_chan.out_byte_0  = rsp_ff.out_bytes[0];
   assign rsp_chan.out_byte_1  = rsp_ff.out_bytes[1];
   assign rsp_chan.out_byte_2  = rsp_ff.out_bytes[2];
   assign rsp_chan.out_byte_3  = rsp_ff.out_bytes[3];
   assign rsp_chan.out_byte_4  = rsp_ff.out_bytes[4];
   assign rsp_chan.out_byte_5  = rsp_ff.out_bytes[5];
   assign rsp_chan.out_byte_6  = rsp_ff.out_bytes[6];
   assign rsp_chan.out_byte_7  = rsp_ff.out_bytes[7];
   assign rsp_chan.last_of_run = rsp_ff.last_of_run;

   // The clearing pass runs to its last address before any tile is taken.
   a_clear_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_addr_ff != CLR_LAST) |=> (state_ff == ST_CLEAR))
      else $error("clearing pass left early");

   // A page update burst only runs while the page is marked dirty.
   a_burst_dirty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMD || state_ff == ST_FETCH || state_ff == ST_EMIT) |-> dirty_ff)
      else $error("burst without dirty page");

   // Data words stay within the recorded dirty span.
   a_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (k_ff >= first_ff && k_ff <= last_ff))
      else $error("data tile outside dirty span");

endmodule

`default_nettype wire
